@@ sv/u8u16_pkg.sv @@
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the byte class limits, code point bounds and surrogate bases.
// No dependencies.
package u8u16_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] unit_t;
  typedef logic [20:0] cp_t;

  // Most code units one byte can cause
  localparam int MAX_UNITS = 4;

  // Byte class limits
  localparam byte_t CONT_MIN  = 8'h80;
  localparam byte_t LEAD2_MIN = 8'hC0;
  localparam byte_t LEAD3_MIN = 8'hE0;
  localparam byte_t LEAD4_MIN = 8'hF0;
  localparam byte_t BAD_MIN   = 8'hF8;

  // Smallest code point for each sequence length, and the top of the range
  localparam cp_t MIN_CP2 = 21'h00080;
  localparam cp_t MIN_CP3 = 21'h00800;
  localparam cp_t MIN_CP4 = 21'h10000;
  localparam cp_t MAX_CP  = 21'h10FFFF;

  // Surrogate bases
  localparam unit_t HI_BASE = 16'hD800;
  localparam unit_t LO_BASE = 16'hDC00;

endpackage

@@ sv/utf8_to_utf16_transcoder.sv @@
// UTF-8 to UTF-16 transcoder, top level.
// An accepted byte waits in the input register; its units are presented from the result register.
// Throughput: one byte per cycle while each byte yields at most one unit and out_ready is
// high; a byte that yields more units (up to 4) holds the unit register until all are taken.
// One byte may wait in the input register while results are stalled.
// Reset (rst, synchronous): no sequence pending, both registers empty; held bytes keep garbage.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        fallback,
  output logic        last_of_run
);

  // Input register
  logic  st_valid;
  byte_t st_byte;
  logic  st_eos;

  // Decoder state
  byte_t      held_bytes [3];
  logic [1:0] held_count;
  logic [1:0] needed_count;

  // Result register: the units of one request, drained one per cycle while out_ready is high
  unit_t      run_unit [MAX_UNITS];
  logic       run_fb   [MAX_UNITS];
  logic [2:0] run_cnt;
  logic [1:0] run_pos;

  // Decode outputs
  unit_t      dec_unit [MAX_UNITS];
  logic       dec_fb   [MAX_UNITS];
  logic [2:0] dec_cnt;
  byte_t      held_next [3];
  logic [1:0] held_count_next;
  logic [1:0] needed_count_next;

  logic  is_cont;
  logic  run_last;
  logic  load_ok;
  logic  advance;
  cp_t   cp;
  cp_t   cp_min;
  cp_t   cp_off;
  unit_t hi_unit;
  unit_t lo_unit;

  assign is_cont  = (st_byte >= CONT_MIN) && (st_byte < LEAD2_MIN);
  assign run_last = ({1'b0, run_pos} == (run_cnt - 3'd1));
  assign load_ok  = (run_cnt == 3'd0) || (out_valid && out_ready && run_last);
  assign advance  = st_valid && load_ok;
  assign in_ready = !st_valid || load_ok;

  // Assemble the code point from the held bytes and the current byte
  always_comb begin
    case (held_count)
      2'd1: begin
        cp     = {10'd0, held_bytes[0][4:0], st_byte[5:0]};
        cp_min = MIN_CP2;
      end
      2'd2: begin
        cp     = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], st_byte[5:0]};
        cp_min = MIN_CP3;
      end
      default: begin
        cp     = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0], st_byte[5:0]};
        cp_min = MIN_CP4;
      end
    endcase
    cp_off  = cp - MIN_CP4;
    hi_unit = HI_BASE + {6'd0, cp_off[19:10]};
    lo_unit = LO_BASE + {6'd0, cp_off[9:0]};
  end

  // Decode one byte into its list of units and the next state
  always_comb begin
    for (int i = 0; i < MAX_UNITS; i++) begin
      dec_unit[i] = '0;
      dec_fb[i]   = 1'b0;
    end
    dec_cnt           = 3'd0;
    held_next         = held_bytes;
    held_count_next   = held_count;
    needed_count_next = needed_count;

    if ((held_count != 2'd0) && is_cont) begin
      if ((needed_count > 2'd1) && (held_count < 2'd3)) begin
        // hold another continuation byte
        held_next[held_count] = st_byte;
        held_count_next       = held_count + 2'd1;
        needed_count_next     = needed_count - 2'd1;
      end else if ((cp < cp_min) || (cp > MAX_CP)) begin
        // overlong or out of range: pass every byte through raw
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < held_count) begin
            dec_unit[dec_cnt[1:0]] = {8'd0, held_bytes[i]};
            dec_fb[dec_cnt[1:0]]   = 1'b1;
            dec_cnt                = dec_cnt + 3'd1;
          end
        end
        dec_unit[dec_cnt[1:0]] = {8'd0, st_byte};
        dec_fb[dec_cnt[1:0]]   = 1'b1;
        dec_cnt                = dec_cnt + 3'd1;
        held_count_next        = 2'd0;
        needed_count_next      = 2'd0;
      end else begin
        held_count_next   = 2'd0;
        needed_count_next = 2'd0;
        if (cp < MIN_CP4) begin
          dec_unit[0] = cp[15:0];
          dec_cnt     = 3'd1;
        end else begin
          dec_unit[0] = hi_unit;
          dec_unit[1] = lo_unit;
          dec_cnt     = 3'd2;
        end
      end
    end else begin
      // broken sequence: flush what is held, then start fresh
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < held_count) begin
          dec_unit[dec_cnt[1:0]] = {8'd0, held_bytes[i]};
          dec_fb[dec_cnt[1:0]]   = 1'b1;
          dec_cnt                = dec_cnt + 3'd1;
        end
      end
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
      if (st_byte < CONT_MIN) begin
        dec_unit[dec_cnt[1:0]] = {8'd0, st_byte};
        dec_fb[dec_cnt[1:0]]   = 1'b0;
        dec_cnt                = dec_cnt + 3'd1;
      end else if ((st_byte < LEAD2_MIN) || (st_byte >= BAD_MIN)) begin
        dec_unit[dec_cnt[1:0]] = {8'd0, st_byte};
        dec_fb[dec_cnt[1:0]]   = 1'b1;
        dec_cnt                = dec_cnt + 3'd1;
      end else begin
        held_next[0]    = st_byte;
        held_count_next = 2'd1;
        if (st_byte < LEAD3_MIN) begin
          needed_count_next = 2'd1;
        end else if (st_byte < LEAD4_MIN) begin
          needed_count_next = 2'd2;
        end else begin
          needed_count_next = 2'd3;
        end
      end
    end

    // end of string: flush a truncated sequence
    if (st_eos && (held_count_next != 2'd0)) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < held_count_next) begin
          dec_unit[dec_cnt[1:0]] = {8'd0, held_next[i]};
          dec_fb[dec_cnt[1:0]]   = 1'b1;
          dec_cnt                = dec_cnt + 3'd1;
        end
      end
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
    end
  end

  // Capture a request into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_valid <= 1'b1;
    end else if (advance) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_byte <= data_byte;
      st_eos  <= end_of_string;
    end
  end

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_count <= 2'd0;
    end else if (advance) begin
      held_count   <= held_count_next;
      needed_count <= needed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_bytes <= held_next;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= 3'd0;
      run_pos <= 2'd0;
    end else if (advance) begin
      run_cnt <= dec_cnt;
      run_pos <= 2'd0;
    end else if (out_valid && out_ready) begin
      if (run_last) begin
        run_cnt <= 3'd0;
        run_pos <= 2'd0;
      end else begin
        run_pos <= run_pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      run_unit <= dec_unit;
      run_fb   <= dec_fb;
    end
  end

  assign out_valid   = (run_cnt != 3'd0);
  assign code_unit   = run_unit[run_pos];
  assign fallback    = run_fb[run_pos];
  assign last_of_run = run_last;

  // Checks
  a_pos_in_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, run_pos} < run_cnt))
    else $error("unit pointer beyond loaded run");

  a_pending_needs: assert property (@(posedge clk) disable iff (rst)
    (held_count != 2'd0) |-> ((needed_count != 2'd0) &&
                              ({1'b0, held_count} + {1'b0, needed_count} >= 3'd2)))
    else $error("pending sequence with inconsistent counts");

  a_idle_no_needs: assert property (@(posedge clk) disable iff (rst)
    (held_count == 2'd0) |-> (needed_count == 2'd0))
    else $error("continuations expected with nothing held");

  a_empty_load: assert property (@(posedge clk) disable iff (rst)
    (advance && (dec_cnt == 3'd0)) |=> !out_valid)
    else $error("result shown for a byte that caused none");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && st_eos) |=> (held_count == 2'd0))
    else $error("sequence still pending after end of string");

endmodule

@@ tb/u8u16_scoreboard_pkg.sv @@
// Scoreboard for the UTF-8 to UTF-16 transcoder testbench.
// Predicts the code units each accepted byte causes and checks the ones the block emits.
// Depends on u8u16_pkg for byte and unit types and the decode limits.
`timescale 1ns / 100ps

package u8u16_scoreboard_pkg;
  import u8u16_pkg::*;

  typedef struct packed {
    unit_t unit;
    logic  fb;
    logic  last;
  } unit_exp_t;

  class utf16_scoreboard;
    byte_t       held [3];
    int unsigned held_cnt;
    int unsigned need_cnt;
    unit_exp_t   due_units [$];
    unit_exp_t   run_units [$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned units_seen;
    int unsigned latin1_seen;
    int unsigned surr_seen;

    function new();
      held_cnt    = 0;
      need_cnt    = 0;
      errors      = 0;
      bytes_seen  = 0;
      units_seen  = 0;
      latin1_seen = 0;
      surr_seen   = 0;
    endfunction

    function void emit(unit_t u, logic fb);
      unit_exp_t rec;
      rec.unit = u;
      rec.fb   = fb;
      rec.last = 1'b0;
      run_units.push_back(rec);
    endfunction

    // Pass every held byte on as Latin-1, oldest first, and drop the sequence
    function void flush_held();
      for (int i = 0; i < held_cnt; i++) emit({8'h00, held[i]}, 1'b1);
      held_cnt = 0;
      need_cnt = 0;
    endfunction

    // Handle a byte with nothing pending: ASCII, raw byte, or a new lead
    function void begin_seq(byte_t b);
      if (b < CONT_MIN) begin
        emit({8'h00, b}, 1'b0);
      end else if (b < LEAD2_MIN || b >= BAD_MIN) begin
        emit({8'h00, b}, 1'b1);
      end else begin
        held[0]  = b;
        held_cnt = 1;
        need_cnt = (b < LEAD3_MIN) ? 1 : (b < LEAD4_MIN) ? 2 : 3;
      end
    endfunction

    // Work out the units one accepted request causes and queue them
    function void note_byte(byte_t b, logic eos);
      int unsigned cp;
      int unsigned lowest;
      int unsigned v;
      unit_exp_t   rec;
      run_units.delete();
      bytes_seen++;
      if (held_cnt != 0) begin
        if (b >= CONT_MIN && b < LEAD2_MIN) begin
          if (need_cnt > 1 && held_cnt < 3) begin
            held[held_cnt] = b;
            held_cnt++;
            need_cnt--;
          end else begin
            case (held_cnt)
              1: begin
                cp = ((32'(held[0]) & 32'h1F) << 6) | (32'(b) & 32'h3F);
                lowest = MIN_CP2;
              end
              2: begin
                cp = ((32'(held[0]) & 32'h0F) << 12) | ((32'(held[1]) & 32'h3F) << 6)
                   | (32'(b) & 32'h3F);
                lowest = MIN_CP3;
              end
              default: begin
                cp = ((32'(held[0]) & 32'h07) << 18) | ((32'(held[1]) & 32'h3F) << 12)
                   | ((32'(held[2]) & 32'h3F) << 6) | (32'(b) & 32'h3F);
                lowest = MIN_CP4;
              end
            endcase
            // Overlong or beyond the Unicode range: every byte goes out raw
            if (cp < lowest || cp > MAX_CP) begin
              flush_held();
              emit({8'h00, b}, 1'b1);
            end else begin
              held_cnt = 0;
              need_cnt = 0;
              if (cp < MIN_CP4) begin
                emit(unit_t'(cp), 1'b0);
              end else begin
                v = cp - MIN_CP4;
                emit(unit_t'(HI_BASE + (v >> 10)), 1'b0);
                emit(unit_t'(LO_BASE + (v & 32'h3FF)), 1'b0);
              end
            end
          end
        end else begin
          flush_held();
          begin_seq(b);
        end
      end else begin
        begin_seq(b);
      end
      // Flush a truncated sequence at the end of the string
      if (eos && held_cnt != 0) flush_held();
      // A lead byte that only starts a sequence causes no unit
      if (run_units.size() != 0) begin
        rec = run_units.pop_back();
        rec.last = 1'b1;
        run_units.push_back(rec);
      end
      foreach (run_units[i]) due_units.push_back(run_units[i]);
    endfunction

    // Compare one emitted unit with the oldest prediction
    function void check_unit(unit_t u, logic fb, logic last);
      unit_exp_t want;
      if (due_units.size() == 0) begin
        $display("%0t: unit %h fallback %b last %b emitted, none expected",
                 $time, u, fb, last);
        errors++;
        return;
      end
      want = due_units.pop_front();
      units_seen++;
      if (want.fb) latin1_seen++;
      if (!want.fb && want.unit >= HI_BASE && want.unit < 16'hE000) surr_seen++;
      if (u !== want.unit) begin
        $display("%0t: code_unit expected %h actual %h", $time, want.unit, u);
        errors++;
      end
      if (fb !== want.fb) begin
        $display("%0t: fallback expected %b actual %b (unit %h)", $time, want.fb, fb,
                 want.unit);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_run expected %b actual %b (unit %h)", $time, want.last,
                 last, want.unit);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/utf8_to_utf16_transcoder_tb.sv @@
// Testbench top for the UTF-8 to UTF-16 transcoder: directed byte strings, then random runs.
// Drives random stalls on both handshakes and checks every unit via u8u16_scoreboard_pkg.
// Depends on u8u16_pkg and the transcoder RTL.
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_tb;
  import u8u16_pkg::*;
  import u8u16_scoreboard_pkg::*;

  localparam int RANDOM_BYTES = 300;

  // Directed strings as {end_of_string, byte}
  localparam logic [8:0] DIRECTED [27] = '{
    9'h000, 9'h07F, 9'h080, 9'h0F8,             // ASCII limits, stray continuation, bad byte
    9'h0C3, 9'h0A9,                             // two-byte
    9'h0E2, 9'h082, 9'h0AC,                     // three-byte
    9'h0F0, 9'h09F, 9'h098, 9'h080,             // four-byte, surrogate pair
    9'h0C1, 9'h0BF,                             // overlong two-byte lead
    9'h0F4, 9'h090, 9'h080, 9'h080,             // above the top code point
    9'h0ED, 9'h0A0, 9'h080,                     // encoded surrogate passes through
    9'h0E2, 9'h041,                             // sequence broken by ASCII
    9'h0F0, 9'h19F,                             // truncated at end of string
    9'h1FF                                      // raw byte ending a string
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        fallback;
  logic        last_of_run;

  utf16_scoreboard sb;
  int unsigned     bytes_sent = 0;
  bit              calm = 1'b0;
  int              stall_left = 0;

  utf8_to_utf16_transcoder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_unit    (code_unit),
    .fallback     (fallback),
    .last_of_run  (last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none during calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one request, hold it until accepted, then idle for a random gap
  task automatic send_byte(input byte_t b, input logic eos);
    int gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, eos);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every predicted unit has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_units.size() != 0) @(negedge clk);
  endtask

  // Send one random run: mostly well-formed sequences, the rest malformed or noise
  task automatic send_random_run();
    byte_t       seq [5];
    int          n;
    int          r;
    int unsigned cp;
    logic        eos;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      seq[0] = byte_t'($urandom_range(0, 'h7F));
      n = 1;
    end else if (r < 40) begin
      cp = $urandom_range('h80, 'h7FF);
      seq[0] = byte_t'(8'hC0 | (cp >> 6));
      seq[1] = byte_t'(8'h80 | (cp & 'h3F));
      n = 2;
    end else if (r < 55) begin
      cp = $urandom_range('h800, 'hFFFF);
      seq[0] = byte_t'(8'hE0 | (cp >> 12));
      seq[1] = byte_t'(8'h80 | ((cp >> 6) & 'h3F));
      seq[2] = byte_t'(8'h80 | (cp & 'h3F));
      n = 3;
    end else if (r < 70) begin
      cp = $urandom_range('h10000, 'h10FFFF);
      seq[0] = byte_t'(8'hF0 | (cp >> 18));
      seq[1] = byte_t'(8'h80 | ((cp >> 12) & 'h3F));
      seq[2] = byte_t'(8'h80 | ((cp >> 6) & 'h3F));
      seq[3] = byte_t'(8'h80 | (cp & 'h3F));
      n = 4;
    end else if (r < 86) begin
      // Leads prone to overlong or out-of-range forms, random continuations
      case ($urandom_range(0, 7))
        0: seq[0] = 8'hC0;
        1: seq[0] = 8'hC1;
        2: seq[0] = 8'hE0;
        3: seq[0] = 8'hF0;
        4: seq[0] = 8'hF4;
        5: seq[0] = 8'hF5;
        6: seq[0] = 8'hF7;
        default: seq[0] = byte_t'($urandom_range('hC0, 'hF7));
      endcase
      n = (seq[0] < LEAD3_MIN) ? 2 : (seq[0] < LEAD4_MIN) ? 3 : 4;
      for (int i = 1; i < n; i++) seq[i] = byte_t'($urandom_range('h80, 'hBF));
      // Break the sequence early with a non-continuation byte
      if (r >= 78) begin
        n = $urandom_range(1, n - 1);
        seq[n] = byte_t'($urandom_range(0, 255));
        if (seq[n] >= CONT_MIN && seq[n] < LEAD2_MIN) seq[n] = seq[n] ^ 8'h40;
        n++;
      end
    end else begin
      seq[0] = byte_t'($urandom_range(0, 255));
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      eos = ($urandom_range(0, 31) == 0) || (i == n - 1 && $urandom_range(0, 7) == 0);
      send_byte(seq[i], eos);
    end
  endtask

  // Stall the result side at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Check each accepted unit
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_unit(code_unit, fallback, last_of_run);
  end

  // End the run if it hangs
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings, then hold off until all their units are out
    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    // Random runs with calm stretches and full drains midway
    while (bytes_sent < $size(DIRECTED) + RANDOM_BYTES) begin
      calm = ((bytes_sent / 40) % 4 == 2);
      send_random_run();
      if (bytes_sent >= 180 && bytes_sent < 184) wait_drained();
    end
    calm = 1'b0;
    wait_drained();
    repeat (16) @(negedge clk);

    $display("Sent %0d bytes; checked %0d code units, %0d Latin-1 fallbacks,",
             sb.bytes_seen, sb.units_seen, sb.latin1_seen);
    $display("and %0d units in the surrogate range; %0d mismatches.",
             sb.surr_seen, sb.errors);
    if (sb.errors == 0 && sb.due_units.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
